@@ rtl/tepq_pkg.sv @@
package tepq_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int TIME_W        = 32;
   localparam int DATA_W        = 64;
   localparam int OCC_W         = 7;

   // operation codes on req_kind
   localparam logic [1:0] KIND_PUSH    = 2'd0;
   localparam logic [1:0] KIND_POP     = 2'd1;
   localparam logic [1:0] KIND_POP_DUE = 2'd2;

   typedef struct packed {
      logic [TIME_W-1:0] stamp;
      logic [DATA_W-1:0] data;
   } tepq_entry_type;

   // what a cell loads at the next edge
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_ABOVE,
      CELL_FROM_BELOW
   } tepq_action_type;

   // x strictly later than y, wraparound order
   function automatic logic later_than(input logic [TIME_W-1:0] x,
                                       input logic [TIME_W-1:0] y);
      logic [TIME_W-1:0] d;
      d = x - y;
      return (d != '0) && !d[TIME_W-1];
   endfunction

endpackage

@@ rtl/timed_event_priority_queue.sv @@
// channel    | ports                                   | transfer when
// -----------+-----------------------------------------+----------------------
// request    | start, busy, req_kind/stamp/payload     | start && !busy
// response   | rsp_strobe, rsp_* result fields         | rsp_strobe (one cycle)
//
// one operation per clock: busy stays low, a response follows every accepted
// request in the next cycle, set by the single update of the cell row
// reset (synchronous, active high) empties the queue; cell contents are not cleared
// the receiver cannot stall: each response is shown for exactly one cycle
// status fields (empty, occupancy, next time) come straight from the stored state
module timed_event_priority_queue #(
   parameter int DEPTH = tepq_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_kind,
   input  logic [tepq_pkg::TIME_W-1:0]   req_stamp,
   input  logic [tepq_pkg::DATA_W-1:0]   req_payload,
   output logic                          rsp_strobe,
   output logic                          rsp_done_res,
   output logic [tepq_pkg::TIME_W-1:0]   rsp_popped_time,
   output logic [tepq_pkg::DATA_W-1:0]   rsp_popped_payload,
   output logic                          rsp_is_empty,
   output logic [tepq_pkg::OCC_W-1:0]    rsp_occupancy,
   output logic [tepq_pkg::TIME_W-1:0]   rsp_next_time
);

   localparam int FILL_W = $clog2(DEPTH + 1);

   // cell 0 holds the earliest event, cell fill-1 the latest
   tepq_pkg::tepq_entry_type  cell_entry [DEPTH];
   tepq_pkg::tepq_action_type cell_action [DEPTH];
   tepq_pkg::tepq_entry_type  new_entry;
   logic [DEPTH-1:0]          new_later;
   logic [DEPTH-1:0]          passes;
   logic [DEPTH-1:0]          reach;
   logic [DEPTH-1:0]          occupied;

   logic [FILL_W-1:0]         fill_ff;
   logic [FILL_W-1:0]         fill_in;
   logic                      rsp_strobe_ff;
   logic                      rsp_done_ff;
   logic                      rsp_done_in;
   logic [tepq_pkg::TIME_W-1:0] rsp_time_ff;
   logic [tepq_pkg::TIME_W-1:0] rsp_time_in;
   logic [tepq_pkg::DATA_W-1:0] rsp_data_ff;
   logic [tepq_pkg::DATA_W-1:0] rsp_data_in;

   logic accept;
   logic is_full;
   logic is_none;
   logic push_ok;
   logic pop_ok;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign is_full   = (fill_ff == FILL_W'(DEPTH));
   assign is_none   = (fill_ff == '0);
   assign new_entry = '{stamp: req_stamp, data: req_payload};

   // decode the operation against the current top
   always_comb begin
      push_ok = 1'b0;
      pop_ok  = 1'b0;
      unique case (req_kind)
         tepq_pkg::KIND_PUSH: push_ok = accept && !is_full;
         tepq_pkg::KIND_POP:  pop_ok  = accept && !is_none;
         tepq_pkg::KIND_POP_DUE: begin
            pop_ok = accept && !is_none &&
                     !tepq_pkg::later_than(cell_entry[0].stamp, req_stamp);
         end
         default: begin
            push_ok = 1'b0;
            pop_ok  = 1'b0;
         end
      endcase
   end

   // a cell passes the new event downward while it is occupied and earlier
   for (genvar k = 0; k < DEPTH; k++) begin : g_occ
      assign occupied[k] = (FILL_W'(k) < fill_ff);
   end
   assign passes = new_later & occupied;

   tepq_scan #(.DEPTH(DEPTH)) u_scan (
      .passes (passes),
      .reach  (reach)
   );

   // per cell: above the slot hold, at the slot load, below it shift down
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         if (push_ok) begin
            if (!reach[k]) begin
               cell_action[k] = tepq_pkg::CELL_FROM_ABOVE;
            end else if (!passes[k]) begin
               cell_action[k] = tepq_pkg::CELL_LOAD;
            end else begin
               cell_action[k] = tepq_pkg::CELL_HOLD;
            end
         end else if (pop_ok) begin
            cell_action[k] = tepq_pkg::CELL_FROM_BELOW;
         end else begin
            cell_action[k] = tepq_pkg::CELL_HOLD;
         end
      end
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      tepq_pkg::tepq_entry_type above;
      tepq_pkg::tepq_entry_type below;
      if (k == 0) begin : g_first
         assign above = new_entry;
      end else begin : g_mid_a
         assign above = cell_entry[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign below = cell_entry[k];
      end else begin : g_mid_b
         assign below = cell_entry[k+1];
      end
      tepq_cell u_cell (
         .clock        (clock),
         .action       (cell_action[k]),
         .new_entry    (new_entry),
         .above_entry  (above),
         .below_entry  (below),
         .entry        (cell_entry[k]),
         .new_is_later (new_later[k])
      );
   end

   // next fill and response payload
   always_comb begin
      fill_in     = fill_ff;
      rsp_done_in = push_ok || pop_ok;
      rsp_time_in = '0;
      rsp_data_in = '0;
      if (push_ok) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (pop_ok) begin
         fill_in     = fill_ff - FILL_W'(1);
         rsp_time_in = cell_entry[0].stamp;
         rsp_data_in = cell_entry[0].data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         fill_ff       <= fill_in;
         rsp_strobe_ff <= accept;
      end
      rsp_done_ff <= rsp_done_in;
      rsp_time_ff <= rsp_time_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_done_res       = rsp_done_ff;
   assign rsp_popped_time    = rsp_time_ff;
   assign rsp_popped_payload = rsp_data_ff;
   // status reflects the state left by the transfer being reported
   assign rsp_is_empty       = is_none;
   assign rsp_occupancy      = tepq_pkg::OCC_W'(fill_ff);
   assign rsp_next_time      = is_none ? '0 : cell_entry[0].stamp;

   // fill never runs past the cell row
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(DEPTH))
      else $error("fill beyond depth");

   // a push into a full queue is refused and leaves the count alone
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == tepq_pkg::KIND_PUSH && is_full)
      |=> (rsp_strobe && !rsp_done_res && fill_ff == $past(fill_ff)))
      else $error("push accepted while full");

   // a successful transfer always moves the count by one
   a_done_moves: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_done_res) |-> (fill_ff != $past(fill_ff)))
      else $error("done without count change");

   // a not-due conditional pop removes nothing
   a_not_due: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == tepq_pkg::KIND_POP_DUE && !is_none &&
       tepq_pkg::later_than(cell_entry[0].stamp, req_stamp))
      |=> (!rsp_done_res && rsp_popped_payload == '0))
      else $error("conditional pop taken before due");

endmodule

@@ rtl/tepq_cell.sv @@
module tepq_cell (
   input  logic                     clock,
   input  tepq_pkg::tepq_action_type action,
   input  tepq_pkg::tepq_entry_type new_entry,
   input  tepq_pkg::tepq_entry_type above_entry,
   input  tepq_pkg::tepq_entry_type below_entry,
   output tepq_pkg::tepq_entry_type entry,
   output logic                     new_is_later
);

   tepq_pkg::tepq_entry_type entry_ff;
   tepq_pkg::tepq_entry_type entry_in;

   always_comb begin
      unique case (action)
         tepq_pkg::CELL_HOLD:       entry_in = entry_ff;
         tepq_pkg::CELL_LOAD:       entry_in = new_entry;
         tepq_pkg::CELL_FROM_ABOVE: entry_in = above_entry;
         tepq_pkg::CELL_FROM_BELOW: entry_in = below_entry;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry        = entry_ff;
   assign new_is_later = tepq_pkg::later_than(new_entry.stamp, entry_ff.stamp);

endmodule

@@ rtl/tepq_scan.sv @@
module tepq_scan #(
   parameter int DEPTH = tepq_pkg::DEPTH_DEFAULT
) (
   input  logic [DEPTH-1:0] passes,
   output logic [DEPTH-1:0] reach
);

   localparam int LEVELS = $clog2(DEPTH);

   // reach[k] = and of passes[k-1:0], log-depth prefix
   always_comb begin
      logic [DEPTH-1:0] acc;
      logic [DEPTH-1:0] nxt;
      acc = {passes[DEPTH-2:0], 1'b1};
      for (int l = 0; l < LEVELS; l++) begin
         nxt = acc;
         for (int k = 0; k < DEPTH; k++) begin
            if (k >= (1 << l)) begin
               nxt[k] = acc[k] & acc[k - (1 << l)];
            end
         end
         acc = nxt;
      end
      reach = acc;
   end

endmodule
